>>> rtl/ise_pkg.sv
package ise_pkg;

   localparam int unsigned DATA_W = 32;

   localparam logic [1:0] MODE_HOLD   = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_SHIFT  = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value_res;
      logic                     last_res;
      logic                     overflow;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic                     le;
      logic signed [DATA_W-1:0] value;
   } cell_type;

endpackage

>>> rtl/ise_cell.sv
module ise_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [1:0]                       mode,
   input  logic signed [ise_pkg::DATA_W-1:0] ins_value,
   input  ise_pkg::cell_type                left,
   input  ise_pkg::cell_type                right,
   output ise_pkg::cell_type                cell_out
);

   logic                              valid_ff;
   logic                              valid_in;
   logic signed [ise_pkg::DATA_W-1:0] value_ff;
   logic signed [ise_pkg::DATA_W-1:0] value_in;
   logic                              le;

   assign le = valid_ff && !(value_ff > ins_value);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      case (mode)
         ise_pkg::MODE_INSERT: begin
            if (!le) begin
               if (left.le) begin
                  valid_in = 1'b1;
                  value_in = ins_value;
               end else begin
                  valid_in = left.valid;
                  value_in = left.value;
               end
            end
         end
         ise_pkg::MODE_SHIFT: begin
            valid_in = right.valid;
            value_in = right.value;
         end
         default: begin
            valid_in = valid_ff;
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_out.valid = valid_ff;
   assign cell_out.le    = le;
   assign cell_out.value = value_ff;

endmodule

>>> rtl/insertion_sort_engine.sv
// Streaming insertion sorter for signed 32-bit values. A row of CAPACITY cells
// keeps the set in ascending order; each accepted beat is compared against every
// cell at once and slots in after all stored values that are not greater, so one
// value is inserted per clock cycle while req_stall is low. A beat with last set
// is inserted too, then the row shifts toward the output one value per cycle
// while rsp_stall is low, and req_stall is high while it drains. Values beyond
// CAPACITY are dropped and every beat of that run carries overflow; last_res
// marks the final beat of the run, after which the row is empty again.
module insertion_sort_engine #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ise_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ise_pkg::rsp_type rsp_data
);

   ise_pkg::cell_type chain [CAPACITY];
   ise_pkg::cell_type head_edge;
   ise_pkg::cell_type tail_edge;

   logic       draining_ff;
   logic       draining_in;
   logic       dropped_ff;
   logic       dropped_in;
   logic       req_fire;
   logic       rsp_fire;
   logic       full;
   logic [1:0] mode;

   assign head_edge.valid = 1'b1;
   assign head_edge.le    = 1'b1;
   assign head_edge.value = '0;
   assign tail_edge.valid = 1'b0;
   assign tail_edge.le    = 1'b0;
   assign tail_edge.value = '0;

   assign full      = chain[CAPACITY-1].valid;
   assign req_stall = draining_ff;
   assign req_fire  = req_valid && !req_stall;

   assign rsp_valid          = draining_ff && chain[0].valid;
   assign rsp_data.value_res = chain[0].value;
   assign rsp_data.last_res  = !chain[1].valid;
   assign rsp_data.overflow  = dropped_ff;
   assign rsp_fire           = rsp_valid && !rsp_stall;

   always_comb begin
      mode = ise_pkg::MODE_HOLD;
      if (rsp_fire) begin
         mode = ise_pkg::MODE_SHIFT;
      end else if (req_fire && !full) begin
         mode = ise_pkg::MODE_INSERT;
      end
   end

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         ise_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .mode      (mode),
            .ins_value (req_data.value),
            .left      ((i == 0) ? head_edge : chain[(i == 0) ? 0 : i-1]),
            .right     ((i == CAPACITY-1) ? tail_edge
                                          : chain[(i == CAPACITY-1) ? i : i+1]),
            .cell_out  (chain[i])
         );
      end
   endgenerate

   always_comb begin
      draining_in = draining_ff;
      dropped_in  = dropped_ff;
      if (req_fire) begin
         if (full) begin
            dropped_in = 1'b1;
         end
         if (req_data.last) begin
            draining_in = 1'b1;
         end
      end
      if (rsp_fire && rsp_data.last_res) begin
         draining_in = 1'b0;
         dropped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff <= 1'b0;
         dropped_ff  <= 1'b0;
      end else begin
         draining_ff <= draining_in;
         dropped_ff  <= dropped_in;
      end
   end

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_data.last_res) |=> rsp_valid)
      else $error("sorted run ended before its last beat");

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_data.last_res) |=> (!chain[0].valid && !dropped_ff))
      else $error("cells or overflow not cleared after final beat");

   a_last_starts_run: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.last) |=> rsp_valid)
      else $error("last beat did not start output");

   a_prefix_valid: assert property (@(posedge clock) disable iff (reset)
      chain[1].valid |-> chain[0].valid)
      else $error("cell row has a hole at its head");

endmodule
